### sv/tdf_pkg.sv
// tdf_pkg: widths and constants for the trial division factorizer.
// No dependencies.
`default_nettype none

package tdf_pkg;

  localparam int VALUE_BITS = 32;              // significant input bits
  localparam int VAL_W      = 32;              // value / prime field width
  localparam int MULT_W     = 5;
  localparam int IDX_W      = 4;
  localparam int D_W        = 17;              // trial divisor, up to 2^16 + 1
  localparam int SQ_W       = 2 * D_W;
  localparam int CNT_W      = $clog2(VAL_W);   // divider bit counter
  localparam int MAX_FACTORS = 9;

  localparam logic [VAL_W-1:0] VALUE_MASK =
    (VALUE_BITS >= VAL_W) ? {VAL_W{1'b1}} : VAL_W'((64'd1 << VALUE_BITS) - 64'd1);

  localparam logic [MULT_W-1:0] MULT_MAX  = {MULT_W{1'b1}};
  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(MAX_FACTORS - 1);

  typedef logic [VAL_W-1:0] val_t;
  typedef logic [D_W-1:0]   div_t;

endpackage

`default_nettype wire

### sv/trial_division_factorizer.sv
// trial_division_factorizer: top level, sequencer around one shared
// bit-serial divider and one squaring multiplier. Depends on tdf_pkg.
//
// Usage:
//   Input: drive in_value and raise start; the transfer happens at a rising
//   edge with start high and busy low. busy stays high until the item is
//   fully factored; no new item is taken meanwhile.
//   Output: one transfer per distinct prime factor, ascending, each shown
//   for exactly one cycle with out_valid high: out_prime, out_multiplicity,
//   out_factor_index (from zero) and out_last on the final factor.
//   Inputs 0 and 1 give no transfers; busy stays low for them.
//   Timing: every trial divisor passes through a square, a compare, a
//   bit-serial division and an evaluate step, and each further division of a
//   prime that divides the value repeats the division and evaluate steps.
//   Divisors 2, 3, 5, 7, 9 ... (2, then every odd number) are tried up to the
//   square root of the remaining value, so the time an item takes grows with
//   that square root and with the number of prime factors with multiplicity;
//   the bit-serial divider dominates it.
//   Reset (rst_n low, synchronous) returns to idle and drops out_valid.
//   The receiver cannot stall: each result is taken in the cycle it shows.
`default_nettype none

module trial_division_factorizer (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               start,
  output logic                              busy,
  input  wire  [tdf_pkg::VAL_W-1:0]         in_value,
  output logic                              out_valid,
  output logic [tdf_pkg::VAL_W-1:0]         out_prime,
  output logic [tdf_pkg::MULT_W-1:0]        out_multiplicity,
  output logic [tdf_pkg::IDX_W-1:0]         out_factor_index,
  output logic                              out_last
);
  import tdf_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQ   = 3'd1;
  localparam logic [2:0] ST_CHK  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_EVAL = 3'd4;

  logic [2:0]        state_r, state_nxt;
  val_t              rem_r, rem_nxt;
  div_t              d_r, d_nxt;
  logic [SQ_W-1:0]   sq_r, sq_nxt;
  val_t              quo_r, quo_nxt;
  div_t              part_r, part_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [MULT_W-1:0] mult_r, mult_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;

  logic              ov_r, ov_nxt;
  val_t              op_r, op_nxt;
  logic [MULT_W-1:0] om_r, om_nxt;
  logic [IDX_W-1:0]  oi_r, oi_nxt;
  logic              ol_r, ol_nxt;

  val_t          in_masked;
  logic [D_W:0]  trial;
  logic          is_last;

  assign in_masked = in_value & VALUE_MASK;
  // one restoring step: shift in next dividend bit, try to subtract divisor
  assign trial   = {part_r, quo_r[VAL_W-1]} - {1'b0, d_r};
  assign is_last = (rem_r == val_t'(1)) || (idx_r == LAST_IDX);

  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    d_nxt     = d_r;
    sq_nxt    = sq_r;
    quo_nxt   = quo_r;
    part_nxt  = part_r;
    cnt_nxt   = cnt_r;
    mult_nxt  = mult_r;
    idx_nxt   = idx_r;
    ov_nxt    = 1'b0;
    op_nxt    = op_r;
    om_nxt    = om_r;
    oi_nxt    = oi_r;
    ol_nxt    = ol_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start && (in_masked > val_t'(1))) begin
          rem_nxt   = in_masked;
          d_nxt     = div_t'(2);
          mult_nxt  = '0;
          idx_nxt   = '0;
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        sq_nxt    = SQ_W'(d_r) * SQ_W'(d_r);
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        if (sq_r > SQ_W'(rem_r)) begin
          // remainder is prime
          ov_nxt    = 1'b1;
          op_nxt    = rem_r;
          om_nxt    = MULT_W'(1);
          oi_nxt    = idx_r;
          ol_nxt    = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          quo_nxt   = rem_r;
          part_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (trial[D_W]) begin
          part_nxt = div_t'({part_r, quo_r[VAL_W-1]});
          quo_nxt  = {quo_r[VAL_W-2:0], 1'b0};
        end else begin
          part_nxt = trial[D_W-1:0];
          quo_nxt  = {quo_r[VAL_W-2:0], 1'b1};
        end
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == {CNT_W{1'b1}}) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (part_r == '0) begin
          rem_nxt   = quo_r;
          if (mult_r != MULT_MAX) begin
            mult_nxt = mult_r + MULT_W'(1);
          end
          quo_nxt   = quo_r;
          part_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end else begin
          d_nxt     = (d_r + div_t'(1)) | div_t'(1);
          state_nxt = ST_SQ;
          if (mult_r != '0) begin
            ov_nxt   = 1'b1;
            op_nxt   = VAL_W'(d_r);
            om_nxt   = mult_r;
            oi_nxt   = idx_r;
            ol_nxt   = is_last;
            idx_nxt  = idx_r + IDX_W'(1);
            mult_nxt = '0;
            if (is_last) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
    rem_r  <= rem_nxt;
    d_r    <= d_nxt;
    sq_r   <= sq_nxt;
    quo_r  <= quo_nxt;
    part_r <= part_nxt;
    cnt_r  <= cnt_nxt;
    mult_r <= mult_nxt;
    idx_r  <= idx_nxt;
    op_r   <= op_nxt;
    om_r   <= om_nxt;
    oi_r   <= oi_nxt;
    ol_r   <= ol_nxt;
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = ov_r;
  assign out_prime        = op_r;
  assign out_multiplicity = om_r;
  assign out_factor_index = oi_r;
  assign out_last         = ol_r;

endmodule

`default_nettype wire
